@@ rtl/hspd_pkg.sv @@
package hspd_pkg;

  // Table geometry.
  localparam int SLOT_COUNT  = 8;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SCAN_BYTES  = 8;
  localparam int STORE_BYTES = 8;
  localparam int STORE_W     = $clog2(STORE_BYTES);
  localparam int POS_W       = 7;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [1:0] {
    OP_MOUNT   = 2'd0,
    OP_UNMOUNT = 2'd1,
    OP_BYTE    = 2'd2,
    OP_EMPTY   = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [6:0] dev;
    logic [7:0] inst;
    logic [7:0] data;
    logic       last;
  } item_t;

  // Front to back: head of the command queue.
  typedef struct packed {
    logic  valid;
    item_t item;
  } link_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] index;
    logic       press;
  } result_t;

endpackage

@@ rtl/hspd_front.sv @@
module hspd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          command_i,
  input  logic [6:0]          dev_address_i,
  input  logic [7:0]          interface_instance_i,
  input  logic [7:0]          report_byte_i,
  input  logic                last_byte_i,
  output hspd_pkg::link_t     link_o,
  input  logic                take_i
);

  hspd_pkg::item_t mem_q [2];
  hspd_pkg::item_t item_d;
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push_ok;
  logic            pop_ok;

  assign full    = (cnt_q == 2'd2);
  assign push_ok = push && !full;
  assign pop_ok  = take_i && (cnt_q != 2'd0);

  // Decode the beat into a queued command.
  always_comb begin
    item_d.op   = hspd_pkg::op_e'(command_i);
    item_d.dev  = dev_address_i;
    item_d.inst = interface_instance_i;
    item_d.data = report_byte_i;
    item_d.last = last_byte_i;
  end

  always_comb begin
    wr_ptr_d = push_ok ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_ok ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  assign link_o.valid = (cnt_q != 2'd0);
  assign link_o.item  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= item_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("command queue count out of range");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_ok && !pop_ok) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("accepted beat did not enter the command queue");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_ok && !push_ok) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("taken beat did not leave the command queue");
`endif

endmodule

@@ rtl/hspd_back.sv @@
module hspd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hspd_pkg::link_t     link_i,
  output logic                take_o,
  output logic                empty,
  input  logic                pop,
  output logic                slot_ok_o,
  output logic [2:0]          slot_index_o,
  output logic                press_detected_o
);

  localparam int SN = hspd_pkg::SLOT_COUNT;
  localparam int SW = hspd_pkg::SLOT_W;
  localparam int NB = hspd_pkg::STORE_BYTES;
  localparam int BW = hspd_pkg::STORE_W;
  localparam int PW = hspd_pkg::POS_W;

  // Slot table.
  logic [SN-1:0] used_q, used_d;
  logic [6:0]    dev_q  [SN];
  logic [6:0]    dev_d  [SN];
  logic [7:0]    inst_q [SN];
  logic [7:0]    inst_d [SN];
  logic [7:0]    prev_q [SN][NB];
  logic [7:0]    prev_d [SN][NB];

  // Report in progress.
  logic [PW-1:0] pos_q, pos_d;
  logic [SW-1:0] cur_slot_q, cur_slot_d;
  logic          cur_valid_q, cur_valid_d;
  logic          press_q, press_d;

  // Result queue.
  hspd_pkg::result_t res_mem_q [2];
  hspd_pkg::result_t res_d;
  logic              res_push;
  logic              res_wr_q, res_rd_q;
  logic [1:0]        res_cnt_q;
  logic              res_pop;

  hspd_pkg::item_t item;
  logic [SN-1:0]   hit;
  logic            hit_any, free_any;
  logic [SW-1:0]   hit_idx, free_idx;
  logic            claim_ok, claim_fresh;
  logic [SW-1:0]   claim_idx;
  logic            start;
  logic            rb_valid, rb_fresh;
  logic [SW-1:0]   rb_slot;
  logic [BW-1:0]   pos_sel;
  logic            in_store, in_scan;
  logic [7:0]      prev_byte;
  logic            press_acc;
  logic [SW-1:0]   res_slot;
  logic [SW+2:0]   idx_ext;

  assign item    = link_i.item;
  assign take_o  = link_i.valid && (res_cnt_q != 2'd2);
  assign empty   = (res_cnt_q == 2'd0);
  assign res_pop = pop && !empty;

  // Key compare against all slots in parallel; lowest index wins.
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < SN; i++) begin
      hit[i] = used_q[i] && (dev_q[i] == item.dev) && (inst_q[i] == item.inst);
    end
    for (int i = SN - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_any = 1'b1;
        hit_idx = SW'(i);
      end
      if (!used_q[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
    claim_ok    = hit_any || free_any;
    claim_fresh = !hit_any && free_any;
    claim_idx   = hit_any ? hit_idx : free_idx;
  end

  // Report byte path.
  always_comb begin
    start     = (pos_q == '0);
    rb_valid  = start ? claim_ok : cur_valid_q;
    rb_slot   = start ? claim_idx : cur_slot_q;
    rb_fresh  = start && claim_fresh;
    in_store  = (pos_q < PW'(NB));
    in_scan   = (pos_q < PW'(hspd_pkg::SCAN_BYTES));
    pos_sel   = pos_q[BW-1:0];
    prev_byte = rb_fresh ? 8'h00 : prev_q[rb_slot][pos_sel];
    press_acc = (!start && press_q) ||
                (rb_valid && in_store && in_scan && ((item.data & ~prev_byte) != 8'h00));
  end

  always_comb begin
    used_d      = used_q;
    dev_d       = dev_q;
    inst_d      = inst_q;
    prev_d      = prev_q;
    pos_d       = pos_q;
    cur_slot_d  = cur_slot_q;
    cur_valid_d = cur_valid_q;
    press_d     = press_q;
    res_push    = 1'b0;
    res_slot    = '0;
    res_d.ok    = 1'b0;
    res_d.press = 1'b0;

    if (take_o) begin
      case (item.op)
        hspd_pkg::OP_MOUNT, hspd_pkg::OP_EMPTY: begin
          pos_d       = '0;
          cur_valid_d = 1'b0;
          press_d     = 1'b0;
          if (claim_fresh) begin
            used_d[free_idx] = 1'b1;
            dev_d[free_idx]  = item.dev;
            inst_d[free_idx] = item.inst;
          end
          // A fresh slot starts clear; an empty report clears a reused one.
          if (claim_fresh || (claim_ok && item.op == hspd_pkg::OP_EMPTY)) begin
            for (int j = 0; j < NB; j++) begin
              prev_d[claim_idx][j] = 8'h00;
            end
          end
          res_push = 1'b1;
          res_d.ok = claim_ok;
          res_slot = claim_ok ? claim_idx : '0;
        end
        hspd_pkg::OP_UNMOUNT: begin
          pos_d       = '0;
          cur_valid_d = 1'b0;
          press_d     = 1'b0;
          if (hit_any) begin
            used_d[hit_idx] = 1'b0;
            for (int j = 0; j < NB; j++) begin
              prev_d[hit_idx][j] = 8'h00;
            end
          end
          res_push = 1'b1;
          res_d.ok = hit_any;
          res_slot = hit_any ? hit_idx : '0;
        end
        default: begin
          if (rb_fresh) begin
            used_d[free_idx] = 1'b1;
            dev_d[free_idx]  = item.dev;
            inst_d[free_idx] = item.inst;
          end
          if (start) begin
            cur_valid_d = claim_ok;
            cur_slot_d  = claim_ok ? claim_idx : '0;
          end
          if (rb_valid && in_store) begin
            for (int j = 0; j < NB; j++) begin
              if (BW'(j) == pos_sel) begin
                prev_d[rb_slot][j] = item.data;
              end else if (rb_fresh || (item.last && (BW'(j) > pos_sel))) begin
                prev_d[rb_slot][j] = 8'h00;
              end
            end
          end
          if (!item.last) begin
            pos_d   = (pos_q == hspd_pkg::POS_MAX) ? pos_q : pos_q + PW'(1);
            press_d = press_acc;
          end else begin
            pos_d       = '0;
            cur_valid_d = 1'b0;
            press_d     = 1'b0;
            res_push    = 1'b1;
            res_d.ok    = rb_valid;
            res_slot    = rb_valid ? rb_slot : '0;
            res_d.press = rb_valid && press_acc;
          end
        end
      endcase
    end

    idx_ext     = {3'b000, res_slot};
    res_d.index = idx_ext[2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      pos_q       <= '0;
      cur_slot_q  <= '0;
      cur_valid_q <= 1'b0;
      press_q     <= 1'b0;
      res_wr_q    <= 1'b0;
      res_rd_q    <= 1'b0;
      res_cnt_q   <= 2'd0;
      for (int i = 0; i < SN; i++) begin
        dev_q[i]  <= '0;
        inst_q[i] <= '0;
        for (int j = 0; j < NB; j++) begin
          prev_q[i][j] <= '0;
        end
      end
    end else begin
      used_q      <= used_d;
      dev_q       <= dev_d;
      inst_q      <= inst_d;
      prev_q      <= prev_d;
      pos_q       <= pos_d;
      cur_slot_q  <= cur_slot_d;
      cur_valid_q <= cur_valid_d;
      press_q     <= press_d;
      res_wr_q    <= res_push ? ~res_wr_q : res_wr_q;
      res_rd_q    <= res_pop ? ~res_rd_q : res_rd_q;
      res_cnt_q   <= res_cnt_q + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_d;
    end
  end

  assign slot_ok_o        = res_mem_q[res_rd_q].ok;
  assign slot_index_o     = res_mem_q[res_rd_q].index;
  assign press_detected_o = res_mem_q[res_rd_q].press;

`ifndef NO_ASSERTIONS
  a_cur_slot_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> used_q[cur_slot_q])
    else $error("report in progress points at a free slot");

  a_idle_tracker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) |-> (!cur_valid_q && !press_q))
    else $error("report tracker not cleared between reports");

  a_press_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    press_q |-> cur_valid_q)
    else $error("press recorded without a claimed slot");
`endif

endmodule

@@ rtl/hid_slot_press_detector.sv @@
// Channel   Handshake        Payload
// input     push / full      command_i, dev_address_i, interface_instance_i,
//                            report_byte_i, last_byte_i
// result    pop / empty      slot_ok_o, slot_index_o, press_detected_o
//
// The back end executes one queued beat per cycle while its result queue has
// room, so the block sustains one input beat per cycle; a combinational slot
// lookup and table update set that. A result is registered in the result queue.
// Reset is asynchronous and leaves every slot free; there is no clearing pass.
// Each side has a two-entry queue, so a stalled result side holds back the
// input only once both queues are full.
module hid_slot_press_detector (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] command_i,
  input  logic [6:0] dev_address_i,
  input  logic [7:0] interface_instance_i,
  input  logic [7:0] report_byte_i,
  input  logic       last_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic       slot_ok_o,
  output logic [2:0] slot_index_o,
  output logic       press_detected_o
);

  // Head of the command queue, handed from the front end to the back end.
  hspd_pkg::link_t link;
  // The back end takes the head beat whenever its result queue has room.
  logic            take;

  // Front end: accepts beats, decodes the command and buffers them.
  hspd_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .push                 (push),
    .full                 (full),
    .command_i            (command_i),
    .dev_address_i        (dev_address_i),
    .interface_instance_i (interface_instance_i),
    .report_byte_i        (report_byte_i),
    .last_byte_i          (last_byte_i),
    .link_o               (link),
    .take_i               (take)
  );

  // Back end: slot table, report tracking, press detection and the result
  // queue. Mount, unmount and empty report give one result each; report
  // bytes give a result only on the last byte of the report.
  hspd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .link_i           (link),
    .take_o           (take),
    .empty            (empty),
    .pop              (pop),
    .slot_ok_o        (slot_ok_o),
    .slot_index_o     (slot_index_o),
    .press_detected_o (press_detected_o)
  );

endmodule
